>>> sv/dcs_pkg.sv
// Shared constants and types for the delimited comment stripper.
`default_nettype none

package dcs_pkg;

   localparam int MAX_DELIM = 8;
   // Delimiter registers hold at most eight bytes.
   localparam int DELIM_CAP = (MAX_DELIM < 8) ? MAX_DELIM : 8;
   localparam int WIN_IDX_W = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
   localparam int FILL_W    = $clog2(MAX_DELIM + 1);
   localparam int SKIP_W    = (DELIM_CAP > 1) ? $clog2(DELIM_CAP) : 1;
   localparam int BYTE_W    = 8;
   localparam int PAT_W     = 64;
   localparam int LEN_W     = 4;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BEGIN_PATTERN = 2'd0,
      CSR_BEGIN_LENGTH  = 2'd1,
      CSR_END_PATTERN   = 2'd2,
      CSR_END_LENGTH    = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_CHAR     = 1'b0,
      KIND_LINE_END = 1'b1
   } item_kind_type;

   typedef logic [BYTE_W-1:0] win_type [MAX_DELIM];

   typedef struct packed {
      logic              keep;
      logic              in_cmt;
      logic [SKIP_W-1:0] skip;
   } decision_type;

endpackage

`default_nettype wire

>>> sv/delimited_comment_stripper_unit.sv
// Top level of the delimited comment stripper: window, decider, flush sequencer, result register.
`default_nettype none

//  channel  | direction | ports
//  ---------+-----------+------------------------------------------------------
//  req      | in        | req_valid, req_stall, req_text_byte, req_line_last
//  rsp      | out       | rsp_valid, rsp_stall, rsp_item_kind, rsp_out_byte, rsp_run_last
//  csr      | in        | csr_we, csr_index, csr_wdata
//
// A byte that is not the last of its line is taken while req_stall is low; at most one
// result per transfer is written into the result register.
// A line-end byte starts a flush of the lookahead window: one head byte is decided
// per cycle while the result register is free, then a final step sends the line-end
// marker if the line kept a byte; req_stall is high for the whole flush.
// Reset is synchronous and clears control state; window contents need no reset.
// A stalled result blocks only transfers of a byte that fills the window.

module delimited_comment_stripper_unit (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire [dcs_pkg::BYTE_W-1:0]     req_text_byte,
   input  wire                           req_line_last,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic                          rsp_item_kind,
   output logic [dcs_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_run_last,
   input  wire                           csr_we,
   input  wire [dcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [dcs_pkg::PAT_W-1:0]      csr_wdata
);

   localparam int MAXD = dcs_pkg::MAX_DELIM;
   localparam int FW   = dcs_pkg::FILL_W;
   localparam int SW   = dcs_pkg::SKIP_W;

   // Configuration
   logic [dcs_pkg::PAT_W-1:0] begin_pat_ff, end_pat_ff;
   logic [dcs_pkg::LEN_W-1:0] begin_len_ff, end_len_ff;

   // Stream state
   dcs_pkg::win_type  win_ff, win_in, win_app, dec_win, win_shift;
   logic [FW-1:0]     fill_ff, fill_in, dec_fill;
   logic              in_cmt_ff, in_cmt_in;
   logic [SW-1:0]     skip_ff, skip_in;
   logic              kept_ff, kept_in;
   logic              flushing_ff, flushing_in;

   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   logic [dcs_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                  out_free, req_fire, full_next, flush_step;
   logic [FW-1:0]         begin_eff, end_eff;
   logic                  begin_hit, end_hit;
   dcs_pkg::decision_type dec;

   function automatic logic [FW-1:0] eff_len(input logic [dcs_pkg::LEN_W-1:0] len);
      logic [dcs_pkg::LEN_W-1:0] l;
      l = len;
      if (l == '0) l = dcs_pkg::LEN_W'(1);
      if (int'(l) > dcs_pkg::DELIM_CAP) l = dcs_pkg::LEN_W'(dcs_pkg::DELIM_CAP);
      return FW'(l);
   endfunction

   function automatic logic window_match(input dcs_pkg::win_type win,
                                         input logic [FW-1:0] fill,
                                         input logic [dcs_pkg::PAT_W-1:0] pat,
                                         input logic [FW-1:0] len);
      logic ok;
      ok = (len <= fill);
      for (int k = 0; k < dcs_pkg::DELIM_CAP; k++) begin
         if ((FW'(k) < len) && (win[k] != pat[8*k +: 8])) ok = 1'b0;
      end
      return ok;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // Only a byte that fills the window can produce a result at transfer time.
   assign req_stall = flushing_ff ||
                      (!out_free && (fill_ff == FW'(MAXD - 1)));
   assign req_fire   = req_valid && !req_stall;
   assign full_next  = (fill_ff == FW'(MAXD - 1)) && !req_line_last;
   assign flush_step = flushing_ff && out_free;

   always_comb begin
      win_app = win_ff;
      win_app[fill_ff[dcs_pkg::WIN_IDX_W-1:0]] = req_text_byte;
   end

   // One decider serves both the streaming path and the flush sequencer.
   always_comb begin
      if (flushing_ff) dec_win = win_ff;
      else dec_win = win_app;
   end
   assign dec_fill = flushing_ff ? fill_ff : FW'(fill_ff + 1'b1);

   always_comb begin
      for (int k = 0; k < MAXD - 1; k++) win_shift[k] = dec_win[k+1];
      win_shift[MAXD-1] = dec_win[MAXD-1];
   end

   assign begin_eff = eff_len(begin_len_ff);
   assign end_eff   = eff_len(end_len_ff);
   assign begin_hit = window_match(dec_win, dec_fill, begin_pat_ff, begin_eff);
   assign end_hit   = window_match(dec_win, dec_fill, end_pat_ff, end_eff);

   always_comb begin
      dec.keep   = 1'b0;
      dec.in_cmt = in_cmt_ff;
      dec.skip   = skip_ff;
      if (skip_ff != '0) begin
         dec.skip = SW'(skip_ff - 1'b1);
      end else if (in_cmt_ff) begin
         if (end_hit) begin
            dec.in_cmt = 1'b0;
            dec.skip   = SW'(end_eff - 1'b1);
         end
      end else if (begin_hit) begin
         dec.in_cmt = 1'b1;
         dec.skip   = SW'(begin_eff - 1'b1);
      end else begin
         dec.keep = 1'b1;
      end
   end

   always_comb begin
      win_in       = win_ff;
      fill_in      = fill_ff;
      in_cmt_in    = in_cmt_ff;
      skip_in      = skip_ff;
      kept_in      = kept_ff;
      flushing_in  = flushing_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) rsp_valid_in = 1'b0;

      if (flush_step) begin
         if (fill_ff != '0) begin
            win_in    = win_shift;
            fill_in   = FW'(fill_ff - 1'b1);
            in_cmt_in = dec.in_cmt;
            skip_in   = dec.skip;
            if (dec.keep) begin
               // A kept byte during a flush is always followed by the marker.
               kept_in      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = dcs_pkg::KIND_CHAR;
               rsp_byte_in  = dec_win[0];
               rsp_last_in  = 1'b0;
            end
         end else begin
            flushing_in = 1'b0;
            skip_in     = '0;
            kept_in     = 1'b0;
            if (kept_ff) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = dcs_pkg::KIND_LINE_END;
               rsp_byte_in  = '0;
               rsp_last_in  = 1'b1;
            end
         end
      end else if (req_fire) begin
         if (full_next) begin
            win_in    = win_shift;
            fill_in   = fill_ff;
            in_cmt_in = dec.in_cmt;
            skip_in   = dec.skip;
            if (dec.keep) begin
               kept_in      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = dcs_pkg::KIND_CHAR;
               rsp_byte_in  = dec_win[0];
               rsp_last_in  = 1'b1;
            end
         end else begin
            win_in      = win_app;
            fill_in     = FW'(fill_ff + 1'b1);
            flushing_in = req_line_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         begin_pat_ff <= '0;
         begin_len_ff <= dcs_pkg::LEN_W'(1);
         end_pat_ff   <= '0;
         end_len_ff   <= dcs_pkg::LEN_W'(1);
      end else if (csr_we) begin
         unique case (dcs_pkg::csr_index_type'(csr_index))
            dcs_pkg::CSR_BEGIN_PATTERN: begin_pat_ff <= csr_wdata;
            dcs_pkg::CSR_BEGIN_LENGTH:  begin_len_ff <= csr_wdata[dcs_pkg::LEN_W-1:0];
            dcs_pkg::CSR_END_PATTERN:   end_pat_ff   <= csr_wdata;
            dcs_pkg::CSR_END_LENGTH:    end_len_ff   <= csr_wdata[dcs_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         in_cmt_ff    <= 1'b0;
         skip_ff      <= '0;
         kept_ff      <= 1'b0;
         flushing_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         in_cmt_ff    <= in_cmt_in;
         skip_ff      <= skip_in;
         kept_ff      <= kept_in;
         flushing_ff  <= flushing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item_kind = rsp_kind_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_run_last  = rsp_last_ff;

   // Between lines the window is never full.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      !flushing_ff |-> (fill_ff < FW'(MAXD)))
      else $error("window full outside a flush");

   // The bytes still to skip are always present in the window.
   a_skip_in_window: assert property (@(posedge clock) disable iff (reset)
      FW'(skip_ff) <= fill_ff)
      else $error("skip count exceeds window fill");

   // A line-end byte starts a flush.
   a_last_starts_flush: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_line_last) |=> flushing_ff)
      else $error("line end did not start a flush");

   // The marker closes the run of results of its input.
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == dcs_pkg::KIND_LINE_END)) |-> rsp_last_ff)
      else $error("line-end marker without run_last");

   // A flush ends with an empty window and no pending skip.
   a_flush_exit: assert property (@(posedge clock) disable iff (reset)
      $fell(flushing_ff) |-> ((fill_ff == '0) && (skip_ff == '0) && !kept_ff))
      else $error("flush ended with state left over");

endmodule

`default_nettype wire

>>> verif/dcs_stripper_checker.sv
// Checker for the comment stripper: tracks the delimiters, predicts kept bytes and compares.
`timescale 1ns / 100ps

module dcs_stripper_checker (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   input  wire                           req_stall,
   input  wire [dcs_pkg::BYTE_W-1:0]     req_text_byte,
   input  wire                           req_line_last,
   input  wire                           rsp_valid,
   input  wire                           rsp_stall,
   input  wire                           rsp_item_kind,
   input  wire [dcs_pkg::BYTE_W-1:0]     rsp_out_byte,
   input  wire                           rsp_run_last,
   input  wire                           csr_we,
   input  wire [dcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [dcs_pkg::PAT_W-1:0]      csr_wdata,
   output int                            fail_count,
   output int                            pending_count
);

   typedef struct packed {
      dcs_pkg::item_kind_type     kind;
      logic [dcs_pkg::BYTE_W-1:0] text;
      logic                       run_last;
   } stripped_item_type;

   // Delimiter registers as the block should hold them.
   logic [dcs_pkg::PAT_W-1:0] open_pat;
   logic [dcs_pkg::LEN_W-1:0] open_len;
   logic [dcs_pkg::PAT_W-1:0] close_pat;
   logic [dcs_pkg::LEN_W-1:0] close_len;

   // Predicted stripper state.
   logic [dcs_pkg::BYTE_W-1:0] window_q [dcs_pkg::MAX_DELIM];
   int                         fill;
   bit                         comment_open;
   int                         skip_left;
   bit                         line_kept;

   stripped_item_type step_q[$];
   stripped_item_type stripped_q[$];

   function automatic int delim_bytes(input logic [dcs_pkg::LEN_W-1:0] raw);
      int n;
      n = raw;
      if (n == 0) n = 1;
      if (n > dcs_pkg::DELIM_CAP) n = dcs_pkg::DELIM_CAP;
      return n;
   endfunction

   function automatic bit delim_at_head(input logic [dcs_pkg::PAT_W-1:0] pat, input int n);
      if (n > fill) return 1'b0;
      for (int k = 0; k < n; k++) begin
         if (window_q[k] != pat[8*k +: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Decides the byte at the head of the window and shifts it out.
   function automatic void retire_head();
      int n;
      if (skip_left > 0) begin
         skip_left--;
      end else if (comment_open) begin
         n = delim_bytes(close_len);
         if (delim_at_head(close_pat, n)) begin
            comment_open = 1'b0;
            skip_left = n - 1;
         end
      end else begin
         n = delim_bytes(open_len);
         if (delim_at_head(open_pat, n)) begin
            comment_open = 1'b1;
            skip_left = n - 1;
         end else begin
            step_q.push_back('{dcs_pkg::KIND_CHAR, window_q[0], 1'b0});
            line_kept = 1'b1;
         end
      end
      for (int k = 1; k < fill; k++) window_q[k-1] = window_q[k];
      fill--;
   endfunction

   function automatic void predict_byte(input logic [dcs_pkg::BYTE_W-1:0] text,
                                        input logic last);
      step_q.delete();
      if (fill < dcs_pkg::MAX_DELIM) begin
         window_q[fill] = text;
         fill++;
      end
      if (last) begin
         while (fill > 0) retire_head();
         skip_left = 0;
         if (line_kept) step_q.push_back('{dcs_pkg::KIND_LINE_END, '0, 1'b0});
         line_kept = 1'b0;
      end else if (fill >= dcs_pkg::MAX_DELIM) begin
         retire_head();
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
      foreach (step_q[i]) stripped_q.push_back(step_q[i]);
   endfunction

   function automatic void check_result();
      stripped_item_type want;
      if (stripped_q.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual kind %0d byte %02h last %0d",
                  $time, rsp_item_kind, rsp_out_byte, rsp_run_last);
         fail_count++;
         return;
      end
      want = stripped_q.pop_front();
      if (rsp_item_kind !== want.kind) begin
         $display("%0t: item_kind expected %0d actual %0d", $time, want.kind, rsp_item_kind);
         fail_count++;
      end
      if (rsp_out_byte !== want.text) begin
         $display("%0t: out_byte expected %02h actual %02h", $time, want.text, rsp_out_byte);
         fail_count++;
      end
      if (rsp_run_last !== want.run_last) begin
         $display("%0t: run_last expected %0d actual %0d", $time, want.run_last, rsp_run_last);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         open_pat = '0;
         open_len = 1;
         close_pat = '0;
         close_len = 1;
         fill = 0;
         comment_open = 1'b0;
         skip_left = 0;
         line_kept = 1'b0;
         stripped_q.delete();
         fail_count = 0;
      end else begin
         // Results are registered, so a result never belongs to a byte taken at the same edge.
         if (rsp_valid && !rsp_stall) check_result();
         if (csr_we) begin
            case (csr_index)
               dcs_pkg::CSR_BEGIN_PATTERN: open_pat = csr_wdata;
               dcs_pkg::CSR_BEGIN_LENGTH:  open_len = csr_wdata[dcs_pkg::LEN_W-1:0];
               dcs_pkg::CSR_END_PATTERN:   close_pat = csr_wdata;
               dcs_pkg::CSR_END_LENGTH:    close_len = csr_wdata[dcs_pkg::LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_byte(req_text_byte, req_line_last);
      end
      pending_count = stripped_q.size();
   end

endmodule

>>> verif/tb.sv
// Testbench top for the delimited comment stripper: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 2 * (dcs_pkg::MAX_DELIM + 2);
   localparam int PHASE_ITEMS   = 80;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [dcs_pkg::BYTE_W-1:0]    req_text_byte = '0;
   logic                          req_line_last = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_item_kind;
   logic [dcs_pkg::BYTE_W-1:0]    rsp_out_byte;
   logic                          rsp_run_last;
   logic                          csr_we = 1'b0;
   logic [dcs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [dcs_pkg::PAT_W-1:0]     csr_wdata = '0;

   int fail_count;
   int pending_count;
   int quiet_cycles = 0;
   int burst_left = 0;
   int items_sent = 0;
   int stall_mode = 0;
   int stall_span = 0;

   // Delimiters currently programmed, used to build text that hits them.
   logic [dcs_pkg::PAT_W-1:0]  gen_open_pat = '0;
   int                         gen_open_n = 1;
   logic [dcs_pkg::PAT_W-1:0]  gen_close_pat = '0;
   int                         gen_close_n = 1;
   logic [dcs_pkg::BYTE_W-1:0] line_bytes[$];

   always #2 clock = ~clock;

   delimited_comment_stripper_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .req_line_last (req_line_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item_kind (rsp_item_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   dcs_stripper_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .req_line_last (req_line_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item_kind (rsp_item_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // The receiver switches between free running, light and heavy stalling.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_span = $urandom_range(16, 128);
      end
      stall_span--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic push_byte(input logic [dcs_pkg::BYTE_W-1:0] text, input logic last);
      int gap;
      if (burst_left == 0) begin
         // The gap is never empty, so valid is never lowered and raised in one step.
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_text_byte <= text;
      req_line_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      burst_left--;
      if (burst_left == 0) req_valid <= 1'b0;
   endtask

   task automatic end_burst();
      if (burst_left != 0) begin
         req_valid <= 1'b0;
         burst_left = 0;
      end
   endtask

   // Stops sending and waits until every predicted result has arrived and the
   // window flush of a line without kept bytes has had time to finish.
   task automatic settle();
      end_burst();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_delims(input logic [dcs_pkg::PAT_W-1:0] open_pat,
                             input logic [dcs_pkg::LEN_W-1:0] open_len,
                             input logic [dcs_pkg::PAT_W-1:0] close_pat,
                             input logic [dcs_pkg::LEN_W-1:0] close_len);
      logic [dcs_pkg::PAT_W-1:0] noise;
      noise = {$urandom, $urandom};
      csr_we <= 1'b1;
      csr_index <= dcs_pkg::CSR_BEGIN_PATTERN;
      csr_wdata <= open_pat;
      @(posedge clock);
      csr_index <= dcs_pkg::CSR_BEGIN_LENGTH;
      csr_wdata <= {noise[dcs_pkg::PAT_W-1:dcs_pkg::LEN_W], open_len};
      @(posedge clock);
      csr_index <= dcs_pkg::CSR_END_PATTERN;
      csr_wdata <= close_pat;
      @(posedge clock);
      csr_index <= dcs_pkg::CSR_END_LENGTH;
      csr_wdata <= {noise[dcs_pkg::LEN_W-1:0], noise[dcs_pkg::PAT_W-1:2*dcs_pkg::LEN_W],
                    close_len};
      @(posedge clock);
      csr_we <= 1'b0;
      gen_open_pat = open_pat;
      gen_open_n = (open_len == 0) ? 1 :
                   ((open_len > dcs_pkg::DELIM_CAP) ? dcs_pkg::DELIM_CAP : open_len);
      gen_close_pat = close_pat;
      gen_close_n = (close_len == 0) ? 1 :
                    ((close_len > dcs_pkg::DELIM_CAP) ? dcs_pkg::DELIM_CAP : close_len);
   endtask

   // A line is a string of tokens: whole delimiters, cut delimiters, delimiter
   // bytes, letters and arbitrary bytes, so that matches and near misses are common.
   task automatic send_random_line();
      int tokens;
      int pick;
      int n;
      bit use_open;
      line_bytes.delete();
      tokens = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(0, 9);
         use_open = $urandom_range(0, 1);
         if (pick < 2) begin
            for (int k = 0; k < gen_open_n; k++) line_bytes.push_back(gen_open_pat[8*k +: 8]);
         end else if (pick < 4) begin
            for (int k = 0; k < gen_close_n; k++) line_bytes.push_back(gen_close_pat[8*k +: 8]);
         end else if (pick == 4) begin
            n = use_open ? gen_open_n : gen_close_n;
            n = (n > 1) ? $urandom_range(1, n - 1) : 1;
            for (int k = 0; k < n; k++)
               line_bytes.push_back(use_open ? gen_open_pat[8*k +: 8] : gen_close_pat[8*k +: 8]);
         end else if (pick == 5) begin
            line_bytes.push_back(dcs_pkg::BYTE_W'($urandom_range(0, 255)));
         end else if (pick == 6) begin
            line_bytes.push_back(dcs_pkg::BYTE_W'($urandom_range("a", "z")));
         end else begin
            n = $urandom_range(0, (use_open ? gen_open_n : gen_close_n) - 1);
            line_bytes.push_back(use_open ? gen_open_pat[8*n +: 8] : gen_close_pat[8*n +: 8]);
         end
      end
      foreach (line_bytes[i]) push_byte(line_bytes[i], i == line_bytes.size() - 1);
   endtask

   task automatic random_phase();
      int start;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_random_line();
      settle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset both delimiters are the single byte zero.
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte("A", 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h7E, 1'b1);
      // A comment opened on one line stays open across the next; empty lines get no marker.
      push_byte(8'h00, 1'b1);
      push_byte(8'h01, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h80, 1'b1);
      settle();

      set_delims({48'h0, "*", "/"}, 4'd2, {48'h0, "/", "*"}, 4'd2);
      push_byte("a", 1'b0);
      push_byte("/", 1'b0);
      push_byte("*", 1'b0);
      push_byte("b", 1'b1);
      // The end delimiter is split by a line end and must not match.
      push_byte("b", 1'b0);
      push_byte("*", 1'b1);
      push_byte("/", 1'b0);
      push_byte("c", 1'b1);
      push_byte("*", 1'b0);
      push_byte("/", 1'b0);
      push_byte("Z", 1'b1);
      random_phase();

      set_delims({$urandom, $urandom}, 4'd8, {$urandom, $urandom}, 4'd8);
      random_phase();

      // A length of zero acts as one and fifteen is cut to the window size.
      set_delims({$urandom, $urandom}, 4'd0, {$urandom, $urandom}, 4'd15);
      random_phase();

      set_delims({dcs_pkg::PAT_W{1'b1}}, 4'd3, {dcs_pkg::PAT_W{1'b0}}, 4'd4);
      random_phase();

      set_delims({48'h0, "#", "#"}, 4'd2, {48'h0, "#", "#"}, 4'd2);
      random_phase();

      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
